// ----- sv/stfr_pkg.sv -----
// package for the seatalk frame receiver
// holds the sequencer and escape state types and the stream constants
// no dependencies
package stfr_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } stfr_state_e;

  typedef enum logic [1:0] {
    ESC_NORMAL   = 2'd0,
    ESC_AFTER_FF = 2'd1,
    ESC_MARKED   = 2'd2
  } stfr_esc_e;

  localparam logic [7:0] ESC_BYTE    = 8'hFF;
  localparam logic [7:0] MARK_BYTE   = 8'h00;
  localparam logic [3:0] LEN_MASK    = 4'hF;
  localparam logic [7:0] BL_NO_SYNC  = 8'd255;
  localparam logic [7:0] BL_ATTR     = 8'd254;
  localparam logic [7:0] BL_BASE     = 8'd2;
  localparam logic [4:0] MAX_RESULTS = 5'd18;
  localparam logic [15:0] COLL_MAX   = 16'hFFFF;

  localparam logic KIND_MSG = 1'b0;
  localparam logic KIND_ERR = 1'b1;

  localparam int TDATA_W = 32;

endpackage

// ----- sv/seatalk_frame_receiver.sv -----
// seatalk frame receiver top level: escape decoding, framing and message replay
// keeps the message bytes in a local synchronous memory
// depends on stfr_pkg
//
// input channel s_axis: one received byte per item, parity-marked stream
// (ff 00 marks a parity-error byte, ff ff is a literal ff)
// output channel m_axis: message bytes in order with tlast on the final one,
// or a single error item (tuser set) on a bad escape sequence
// an item that needs no result is done when it is taken; a bad escape puts its
// error item in the output register at once
// the item that completes a message of n bytes (3 to 18) starts replay from
// the message memory: each byte is first read through the registered read
// port (ST_READ), then loaded into the output register (ST_LOAD), one byte
// at a time; no input is taken during replay
// a stalled output holds its item; replay waits and input stays blocked
// reset clears the decoder, the framing counters, the collision count and the
// output valid flag; the message memory is not cleared and needs no sweep
module seatalk_frame_receiver #(
  parameter int MSG_BYTES = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] raw_byte
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [7:0] msg_byte, [12:8] byte_pos, [28:13] collision_count, [31:29] zero
  output logic [stfr_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic                        m_axis_tlast,
  output logic                        m_axis_tuser    // [0] kind
);
  import stfr_pkg::*;

  localparam int AW = $clog2(MSG_BYTES);
  localparam int FW = $clog2(MSG_BYTES + 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(MSG_BYTES);

  stfr_state_e state_q, state_d;
  stfr_esc_e   esc_q, esc_d;
  logic [7:0]  bl_q, bl_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [15:0] coll_q, coll_d;
  logic [4:0]  rd_idx_q, rd_idx_d;
  logic [4:0]  cnt_q, cnt_d;

  logic        out_valid_q, out_valid_d;
  logic        out_kind_q, out_kind_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic [4:0]  out_pos_q, out_pos_d;
  logic        out_last_q, out_last_d;
  logic [15:0] out_coll_q, out_coll_d;

  logic [7:0]  mem_q [MSG_BYTES];
  logic [7:0]  rdata_q;
  logic        mem_we, mem_re;
  logic [AW-1:0] mem_waddr;

  logic        out_free, accept;
  logic [7:0]  v;
  logic        even_par, do_cmd, do_data, do_err, data_ok, complete;
  logic [7:0]  bl_tmp;
  logic        load_byte;

  assign v        = s_axis_tdata;
  assign even_par = ~^v;
  assign out_free = !out_valid_q || m_axis_tready;
  assign accept   = s_axis_tvalid && s_axis_tready;

  // escape decoding and framing
  always_comb begin
    esc_d   = esc_q;
    do_cmd  = 1'b0;
    do_data = 1'b0;
    do_err  = 1'b0;
    unique case (esc_q)
      ESC_AFTER_FF: begin
        if (v == MARK_BYTE) begin
          esc_d = ESC_MARKED;
        end else if (v == ESC_BYTE) begin
          esc_d   = ESC_NORMAL;
          do_data = 1'b1;
        end else begin
          do_err = 1'b1;
        end
      end
      ESC_MARKED: begin
        esc_d   = ESC_NORMAL;
        do_data = even_par;
        do_cmd  = !even_par;
      end
      default: begin
        esc_d = ESC_NORMAL;
        if (v == ESC_BYTE) begin
          esc_d = ESC_AFTER_FF;
        end else if (even_par) begin
          do_cmd = 1'b1;
        end else begin
          do_data = 1'b1;
        end
      end
    endcase

    data_ok = do_data && (fill_q < FILL_FULL) && (bl_q != 8'd0) && (bl_q != BL_NO_SYNC);
    bl_tmp  = (bl_q == BL_ATTR) ? (BL_BASE + {4'd0, v[3:0] & LEN_MASK}) : bl_q;

    bl_d      = bl_q;
    fill_d    = fill_q;
    coll_d    = coll_q;
    mem_we    = 1'b0;
    mem_waddr = fill_q[AW-1:0];
    complete  = 1'b0;
    if (accept && do_cmd) begin
      if (bl_q != 8'd0 && bl_q < BL_ATTR && coll_q != COLL_MAX) begin
        coll_d = coll_q + 16'd1;
      end
      mem_we    = 1'b1;
      mem_waddr = '0;
      fill_d    = FW'(1);
      bl_d      = BL_ATTR;
    end else if (accept && data_ok) begin
      mem_we   = 1'b1;
      fill_d   = fill_q + FW'(1);
      bl_d     = bl_tmp - 8'd1;
      complete = (bl_tmp == 8'd1);
    end
  end

  // replay sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (complete) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_LOAD;
      ST_LOAD: begin
        if (out_free) begin
          state_d = (rd_idx_q + 5'd1 == cnt_q) ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // replay sequencer: outputs
  always_comb begin
    s_axis_tready = 1'b0;
    mem_re        = 1'b0;
    load_byte     = 1'b0;
    rd_idx_d      = rd_idx_q;
    cnt_d         = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = out_free;
        if (complete) begin
          rd_idx_d = '0;
          cnt_d    = (fill_d > FW'(MAX_RESULTS)) ? MAX_RESULTS : fill_d[4:0];
        end
      end
      ST_READ: mem_re = 1'b1;
      ST_LOAD: begin
        if (out_free) begin
          load_byte = 1'b1;
          rd_idx_d  = rd_idx_q + 5'd1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    out_kind_d  = out_kind_q;
    out_byte_d  = out_byte_q;
    out_pos_d   = out_pos_q;
    out_last_d  = out_last_q;
    out_coll_d  = out_coll_q;
    if (accept && do_err) begin
      out_valid_d = 1'b1;
      out_kind_d  = KIND_ERR;
      out_byte_d  = '0;
      out_pos_d   = '0;
      out_last_d  = 1'b1;
      out_coll_d  = coll_q;
    end else if (load_byte) begin
      out_valid_d = 1'b1;
      out_kind_d  = KIND_MSG;
      out_byte_d  = rdata_q;
      out_pos_d   = rd_idx_q;
      out_last_d  = (rd_idx_q + 5'd1 == cnt_q);
      out_coll_d  = coll_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      esc_q       <= ESC_NORMAL;
      bl_q        <= BL_NO_SYNC;
      fill_q      <= '0;
      coll_q      <= '0;
      rd_idx_q    <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (accept) begin
        esc_q <= esc_d;
      end
      bl_q        <= bl_d;
      fill_q      <= fill_d;
      coll_q      <= coll_d;
      rd_idx_q    <= rd_idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q <= out_kind_d;
    out_byte_q <= out_byte_d;
    out_pos_q  <= out_pos_d;
    out_last_q <= out_last_d;
    out_coll_q <= out_coll_d;
  end

  // message memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= v;
    end
    if (mem_re) begin
      rdata_q <= mem_q[AW'(rd_idx_q)];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, out_coll_q, out_pos_q, out_byte_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_kind_q;

  a_no_input_in_replay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready)
    else $error("input taken during replay");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (rd_idx_q < cnt_q))
    else $error("replay read past message end");

  a_error_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata[7:0] == 8'd0))
    else $error("malformed error item");

  a_coll_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (coll_q >= $past(coll_q)))
    else $error("collision count went down");

endmodule
